FILE: hdl/fspi_pkg.sv
// Shared types for the first-seen palette indexer.
package fspi_pkg;

   // Widths of the beat fields
   localparam int COMP_W  = 8;
   localparam int COLOR_W = 3 * COMP_W;
   localparam int IDX_W   = 7;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // latch a new pixel, restart the scan
      logic step;    // advance the palette scan by one entry
      logic finish;  // resolve the lookup and load the response register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;       // the entry under compare matches the pixel
      logic miss;      // every valid entry has been compared, none matched
      logic out_free;  // response register can take a beat this cycle
   } ctl_sts_type;

endpackage

FILE: hdl/first_seen_palette_indexer.sv
// Each pixel beat is looked up in a palette of up to PALETTE_SIZE colors kept in first-seen
// order. The palette sits in a single-port memory that is scanned one entry per cycle, with
// the compare in the cycle after the read. The next pixel is accepted only once the scan
// has hit or missed and the response register is free to take the result; a full response
// register holds the scan until it drains. A new color is appended while room remains; once
// full, unknown colors return index 0 with unmapped set. frame_start empties the palette
// before the pixel's lookup. A finished beat waits in the response register, and the next
// pixel may be accepted meanwhile.
module first_seen_palette_indexer #(
   parameter int PALETTE_SIZE = 94
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fspi_pkg::COMP_W-1:0] req_red,
   input  logic [fspi_pkg::COMP_W-1:0] req_green,
   input  logic [fspi_pkg::COMP_W-1:0] req_blue,
   input  logic                        req_frame_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fspi_pkg::IDX_W-1:0]  rsp_color_index,
   output logic                        rsp_new_color,
   output logic                        rsp_unmapped,
   output logic [fspi_pkg::IDX_W-1:0]  rsp_palette_count
);

   fspi_pkg::ctl_cmd_type cmd;
   fspi_pkg::ctl_sts_type sts;

   fspi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fspi_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_color_index   (rsp_color_index),
      .rsp_new_color     (rsp_new_color),
      .rsp_unmapped      (rsp_unmapped),
      .rsp_palette_count (rsp_palette_count),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

FILE: hdl/fspi_ctrl.sv
// Controller state machine of the first-seen palette indexer.
module fspi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fspi_pkg::ctl_sts_type sts,
   output fspi_pkg::ctl_cmd_type cmd
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit || sts.miss) begin
               // hold the scan until the response register frees up
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/fspi_datapath.sv
// Datapath of the first-seen palette indexer: palette memory, scan and response register.
module fspi_datapath #(
   parameter int PALETTE_SIZE = 94
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [fspi_pkg::COMP_W-1:0]        req_red,
   input  logic [fspi_pkg::COMP_W-1:0]        req_green,
   input  logic [fspi_pkg::COMP_W-1:0]        req_blue,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fspi_pkg::IDX_W-1:0]         rsp_color_index,
   output logic                               rsp_new_color,
   output logic                               rsp_unmapped,
   output logic [fspi_pkg::IDX_W-1:0]         rsp_palette_count,
   input  fspi_pkg::ctl_cmd_type              cmd,
   output fspi_pkg::ctl_sts_type              sts
);

   localparam int CW = $clog2(PALETTE_SIZE + 1);
   localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int OW = fspi_pkg::IDX_W;
   localparam int XW = fspi_pkg::COLOR_W;
   localparam logic [CW-1:0] FULL = CW'(PALETTE_SIZE);

   logic [XW-1:0] palette_mem [PALETTE_SIZE];

   logic [XW-1:0] pixel_ff, pixel_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [XW-1:0] rd_data_ff;
   logic          rd_en;
   logic          wr_en;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_new_ff, rsp_new_in;
   logic          rsp_unmap_ff, rsp_unmap_in;
   logic [OW-1:0] rsp_count_ff, rsp_count_in;

   // Scan status
   always_comb begin
      sts.hit      = cmp_valid_ff && (rd_data_ff == pixel_ff);
      sts.miss     = !cmp_valid_ff && (scan_ff == count_ff);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next values
   always_comb begin
      pixel_in     = pixel_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_unmap_in = rsp_unmap_ff;
      rsp_count_in = rsp_count_ff;

      if (cmd.load) begin
         pixel_in     = {req_red, req_green, req_blue};
         count_in     = req_frame_start ? '0 : count_ff;
         scan_in      = '0;
         cmp_valid_in = 1'b0;
      end

      // one entry read per cycle, compared on the next
      if (cmd.step) begin
         if (scan_ff < count_ff) begin
            rd_en        = 1'b1;
            cmp_idx_in   = scan_ff[AW-1:0];
            cmp_valid_in = 1'b1;
            scan_in      = scan_ff + 1'b1;
         end else begin
            cmp_valid_in = 1'b0;
         end
      end

      // resolve: known color, append, or palette full
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_new_in   = 1'b0;
         rsp_unmap_in = 1'b0;
         if (sts.hit) begin
            rsp_idx_in = OW'(cmp_idx_ff);
         end else if (count_ff != FULL) begin
            wr_en      = 1'b1;
            count_in   = count_ff + 1'b1;
            rsp_idx_in = OW'(count_ff);
            rsp_new_in = 1'b1;
         end else begin
            rsp_idx_in   = '0;
            rsp_unmap_in = 1'b1;
         end
         rsp_count_in = OW'(count_in);
      end
   end

   // Palette memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[count_ff[AW-1:0]] <= pixel_ff;
      end
      if (rd_en) begin
         rd_data_ff <= palette_mem[scan_ff[AW-1:0]];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pixel_ff     <= pixel_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_unmap_ff <= rsp_unmap_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_color_index   = rsp_idx_ff;
   assign rsp_new_color     = rsp_new_ff;
   assign rsp_unmapped      = rsp_unmap_ff;
   assign rsp_palette_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("palette count beyond palette size");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= count_ff)
      else $error("scan index ran past the palette count");

   a_new_xor_unmap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_unmap_ff))
      else $error("beat flagged both new and unmapped");

   a_new_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_new_ff) |-> (OW'(rsp_idx_ff + 1'b1) == rsp_count_ff))
      else $error("new color not placed at the end of the palette");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (sts.out_free && (sts.hit || sts.miss)))
      else $error("finish issued without a resolved lookup or a free response slot");
`endif

endmodule

FILE: test/first_seen_palette_indexer_tb.sv
// Self-checking testbench for the first-seen palette indexer: directed pixels and random frames vs. a predictor.
`timescale 1ns / 1ps

module first_seen_palette_indexer_tb;

   localparam int COMP_W        = fspi_pkg::COMP_W;
   localparam int COLOR_W       = fspi_pkg::COLOR_W;
   localparam int IDX_W         = fspi_pkg::IDX_W;
   localparam int PALETTE_DEPTH = 94;
   localparam int RESET_CYCLES  = 11;
   localparam int CHUNK_ITEMS   = 200;
   localparam int CHUNKS        = 8;
   localparam int TAIL_CYCLES   = 2 * PALETTE_DEPTH + 20;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef enum logic [1:0] {
      PACE_FREE,
      PACE_SLOW_SENDER,
      PACE_SLOW_RECEIVER,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              frame_start;
   } pixel_type;

   typedef struct packed {
      logic [IDX_W-1:0] color_index;
      logic             new_color;
      logic             unmapped;
      logic [IDX_W-1:0] palette_count;
   } palette_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [COMP_W-1:0] req_red = '0;
   logic [COMP_W-1:0] req_green = '0;
   logic [COMP_W-1:0] req_blue = '0;
   logic             req_frame_start = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [IDX_W-1:0] rsp_color_index;
   logic             rsp_new_color;
   logic             rsp_unmapped;
   logic [IDX_W-1:0] rsp_palette_count;

   pixel_type          pixel_queue[$];
   palette_result_type expected_lookups[$];
   logic [COLOR_W-1:0] palette_colors[PALETTE_DEPTH];
   int                 palette_used = 0;
   pace_type           pace = PACE_FREE;
   int                 error_count = 0;
   int                 cycle_count = 0;
   logic               pixel_taken;
   palette_result_type seen;
   palette_result_type want;

   first_seen_palette_indexer #(
      .PALETTE_SIZE(PALETTE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_color_index(rsp_color_index),
      .rsp_new_color(rsp_new_color),
      .rsp_unmapped(rsp_unmapped),
      .rsp_palette_count(rsp_palette_count)
   );

   always #2 clock = ~clock;

   // Palette lookup predictor: first-seen order, full palette maps to index 0
   function automatic palette_result_type index_pixel(input pixel_type px);
      logic [COLOR_W-1:0] shade;
      palette_result_type res;
      shade = {px.red, px.green, px.blue};
      res = '0;
      if (px.frame_start) palette_used = 0;
      for (int i = 0; i < palette_used; i++) begin
         if (palette_colors[i] == shade) begin
            res.color_index = IDX_W'(i);
            res.palette_count = IDX_W'(palette_used);
            return res;
         end
      end
      if (palette_used < PALETTE_DEPTH) begin
         palette_colors[palette_used] = shade;
         res.color_index = IDX_W'(palette_used);
         res.new_color = 1'b1;
         palette_used++;
      end else begin
         res.unmapped = 1'b1;
      end
      res.palette_count = IDX_W'(palette_used);
      return res;
   endfunction

   function automatic logic roll_stall(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic int sender_idle_pct(input pace_type p);
      case (p)
         PACE_SLOW_SENDER: return 83;
         PACE_BOTH:        return 22;
         default:          return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input pace_type p);
      case (p)
         PACE_SLOW_RECEIVER: return 83;
         PACE_BOTH:          return 22;
         default:            return 0;
      endcase
   endfunction

   function automatic void queue_pixel(input logic [COLOR_W-1:0] shade,
                                       input logic fs);
      pixel_type px;
      px.red = shade[23:16];
      px.green = shade[15:8];
      px.blue = shade[7:0];
      px.frame_start = fs;
      pixel_queue = {pixel_queue, px};
   endfunction

   // Components lean toward the extremes so black, white and primaries show up often
   function automatic logic [COLOR_W-1:0] random_color();
      logic [COMP_W-1:0] comp[3];
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 7))
            0:       comp[k] = 8'h00;
            1:       comp[k] = 8'hFF;
            default: comp[k] = COMP_W'($urandom_range(0, 255));
         endcase
      end
      return {comp[0], comp[1], comp[2]};
   endfunction

   // One image: a color pool, then pixels drawn mostly from it; big pools have at least PALETTE_DEPTH colors
   function automatic int queue_frame(input logic big);
      logic [COLOR_W-1:0] pool[$];
      int pool_size;
      int length;
      int n;
      logic [COLOR_W-1:0] shade;
      logic fs;
      pool_size = big ? $urandom_range(PALETTE_DEPTH, PALETTE_DEPTH + 6) : $urandom_range(1, 24);
      for (int i = 0; i < pool_size; i++) pool = {pool, random_color()};
      n = 0;
      // walk the whole pool first so the palette fills unless the pool repeats a color
      if (big) begin
         foreach (pool[i]) begin
            queue_pixel(pool[i], i == 0);
            n++;
         end
      end
      length = big ? $urandom_range(10, 40) : $urandom_range(4, 60);
      repeat (length) begin
         if ($urandom_range(0, 9) == 0) shade = random_color();
         else shade = pool[$urandom_range(0, pool.size() - 1)];
         // usually frame_start leads the image; sometimes it is missing or stray
         if (n == 0) fs = $urandom_range(0, 7) != 0;
         else fs = $urandom_range(0, 63) == 0;
         queue_pixel(shade, fs);
         n++;
      end
      return n;
   endfunction

   task automatic wait_for_drain();
      while (pixel_queue.size() != 0 || req_valid) @(negedge clock);
      while (expected_lookups.size() != 0) @(negedge clock);
   endtask

   // Driver: present the head of the pixel queue, predict on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         pixel_taken = req_valid && req_ready;
         if (pixel_taken)
            expected_lookups = {expected_lookups, index_pixel(pixel_queue.pop_front())};
         if (!req_valid || pixel_taken) begin
            if (pixel_queue.size() != 0 && !roll_stall(sender_idle_pct(pace))) begin
               req_valid <= 1'b1;
               req_red <= pixel_queue[0].red;
               req_green <= pixel_queue[0].green;
               req_blue <= pixel_queue[0].blue;
               req_frame_start <= pixel_queue[0].frame_start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.color_index = rsp_color_index;
            seen.new_color = rsp_new_color;
            seen.unmapped = rsp_unmapped;
            seen.palette_count = rsp_palette_count;
            if (expected_lookups.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got index %0d new %0b",
                        $time, seen.color_index, seen.new_color);
               $display("%0t: unexpected beat, got unmapped %0b count %0d",
                        $time, seen.unmapped, seen.palette_count);
               error_count++;
            end else begin
               want = expected_lookups.pop_front();
               if (seen.color_index !== want.color_index) begin
                  $display("%0t: color_index expected %0d got %0d",
                           $time, want.color_index, seen.color_index);
                  error_count++;
               end
               if (seen.new_color !== want.new_color) begin
                  $display("%0t: new_color expected %0b got %0b",
                           $time, want.new_color, seen.new_color);
                  error_count++;
               end
               if (seen.unmapped !== want.unmapped) begin
                  $display("%0t: unmapped expected %0b got %0b",
                           $time, want.unmapped, seen.unmapped);
                  error_count++;
               end
               if (seen.palette_count !== want.palette_count) begin
                  $display("%0t: palette_count expected %0d got %0d",
                           $time, want.palette_count, seen.palette_count);
                  error_count++;
               end
            end
         end
         rsp_ready <= !roll_stall(receiver_stall_pct(pace));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("first_seen_palette_indexer_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int queued;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: lookups before any frame start, extremes, one-bit neighbors, clears
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'hFF0000, 1'b0);
      queue_pixel(24'h00FF00, 1'b0);
      queue_pixel(24'h0000FF, 1'b0);
      queue_pixel(24'hFE0000, 1'b0);
      queue_pixel(24'h00FE00, 1'b0);
      queue_pixel(24'h0000FE, 1'b0);
      queue_pixel(24'h010101, 1'b0);
      queue_pixel(24'h808080, 1'b0);
      queue_pixel(24'hFF0000, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b1);
      queue_pixel(24'h000000, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b0);
      queue_pixel(24'h000000, 1'b1);
      queue_pixel(24'h000000, 1'b1);
      queue_pixel(24'h123456, 1'b0);
      queue_pixel(24'hA5A55A, 1'b0);
      queue_pixel(24'h123456, 1'b0);
      // hold off until the directed beats have all come back
      wait_for_drain();

      // Random frames, cycling through the traffic patterns
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         pace = pace_type'(chunk % 4);
         queued = 0;
         for (int f = 0; queued < CHUNK_ITEMS; f++) queued += queue_frame(f % 3 == 2);
         while (pixel_queue.size() != 0) @(negedge clock);
         if (chunk == CHUNKS / 2 - 1) wait_for_drain();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("first_seen_palette_indexer_tb OK");
      else
         $display("first_seen_palette_indexer_tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/fspi_pkg.sv
hdl/fspi_ctrl.sv
hdl/fspi_datapath.sv
hdl/first_seen_palette_indexer.sv
test/first_seen_palette_indexer_tb.sv
